// File: hdl/tlbpt_pkg.sv
// Package for the TLB and page-table translator: sizes, result codes and the
// command and flag structs passed between controller and datapath.
// No dependencies.
package tlbpt_pkg;

  localparam int OFFSET_BITS   = 10;
  localparam int TLB_SETS      = 8;
  localparam int TABLE_ENTRIES = 128;
  localparam int FRAME_BITS    = 15;

  localparam int VADDR_W     = 17;
  localparam int PADDR_W     = 25;
  localparam int ENTRY_IDX_W = 7;
  localparam int ENTRY_PPN_W = 15;
  localparam int STATUS_W    = 2;

  localparam int TABLE_IDX_W = $clog2(TABLE_ENTRIES);
  localparam int SET_W       = $clog2(TLB_SETS);
  localparam int TAG_W       = TABLE_IDX_W - SET_W;

  localparam logic [STATUS_W-1:0] ST_TLB     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAULT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd3;

  localparam logic FUNC_TRANSLATE = 1'b0;
  localparam logic FUNC_WRITE     = 1'b1;

  typedef struct packed {
    logic capture;      // latch the accepted transaction
    logic write_entry;  // store page-table entry and post the acknowledge
    logic read_table;   // start the registered page-table read
    logic finish_hit;   // post a TLB hit result
    logic finish_miss;  // post page-table result or fault, refill on present
  } tlbpt_cmd_t;

  typedef struct packed {
    logic is_write;
    logic tlb_hit;
    logic out_free;
  } tlbpt_flags_t;

endpackage

// File: hdl/tlbpt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tlbpt_ctrl.sv
// Controller state machine of the translator: sequences accept, TLB check,
// page-table read and result posting. Depends on tlbpt_pkg.
module tlbpt_ctrl import tlbpt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  tlbpt_flags_t flags_i,
  output tlbpt_cmd_t   cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_q, state_d;
  tlbpt_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (flags_i.is_write) begin
          if (flags_i.out_free) begin
            cmd.write_entry = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (flags_i.tlb_hit) begin
          if (flags_i.out_free) begin
            cmd.finish_hit = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd.read_table = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        // The read data register holds until the next read, so waiting is safe.
        if (flags_i.out_free) begin
          cmd.finish_miss = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.write_entry, cmd.read_table, cmd.finish_hit, cmd.finish_miss}))
    else $error("controller issued more than one command");

  a_read_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.read_table |=> (state_q == S_READ))
    else $error("page-table read not followed by the read state");

  a_hit_needs_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish_hit |-> (flags_i.tlb_hit && !flags_i.is_write))
    else $error("hit result posted without a TLB hit");

endmodule

// File: hdl/tlbpt_dp.sv
// Datapath of the translator: transaction registers, TLB sets, page-table
// present bits and frame RAM, and the result register.
// Depends on tlbpt_pkg and tlbpt_ram.
module tlbpt_dp import tlbpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlbpt_cmd_t             cmd_i,
  output tlbpt_flags_t           flags_o,
  input  logic                   func_i,
  input  logic [VADDR_W-1:0]     vaddr_i,
  input  logic [ENTRY_IDX_W-1:0] entry_index_i,
  input  logic [ENTRY_PPN_W-1:0] entry_ppn_i,
  input  logic                   entry_valid_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [PADDR_W-1:0]     paddr_o
);

  logic                   func_q;
  logic [VADDR_W-1:0]     vaddr_q;
  logic [ENTRY_IDX_W-1:0] entry_index_q;
  logic [ENTRY_PPN_W-1:0] entry_ppn_q;
  logic                   entry_valid_q;

  logic [TAG_W-1:0]         tlb_tag_q   [TLB_SETS];
  logic [FRAME_BITS-1:0]    tlb_frame_q [TLB_SETS];
  logic [TLB_SETS-1:0]      tlb_present_q;
  logic [TABLE_ENTRIES-1:0] table_present_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [PADDR_W-1:0]    paddr_q;

  logic [OFFSET_BITS-1:0] offset;
  logic [TABLE_IDX_W-1:0] vpn;
  logic [SET_W-1:0]       set_idx;
  logic [TAG_W-1:0]       tag;
  logic [TABLE_IDX_W-1:0] wr_idx;
  logic [FRAME_BITS-1:0]  wr_frame;
  logic [FRAME_BITS-1:0]  ram_rdata;
  logic                   tlb_hit;
  logic                   page_present;
  logic                   out_free;
  logic                   load_out;

  assign offset   = vaddr_q[OFFSET_BITS-1:0];
  assign vpn      = vaddr_q[OFFSET_BITS +: TABLE_IDX_W];
  assign set_idx  = vpn[SET_W-1:0];
  assign tag      = vpn[TABLE_IDX_W-1:SET_W];
  assign wr_idx   = entry_index_q[TABLE_IDX_W-1:0];
  assign wr_frame = entry_ppn_q[FRAME_BITS-1:0];

  assign tlb_hit      = tlb_present_q[set_idx] && (tlb_tag_q[set_idx] == tag);
  assign page_present = table_present_q[vpn];
  assign out_free     = !out_valid_q || !out_stall_i;
  assign load_out     = cmd_i.write_entry || cmd_i.finish_hit || cmd_i.finish_miss;

  assign flags_o.is_write = (func_q == FUNC_WRITE);
  assign flags_o.tlb_hit  = tlb_hit;
  assign flags_o.out_free = out_free;

  tlbpt_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_entry),
    .waddr_i (wr_idx),
    .wdata_i (wr_frame),
    .re_i    (cmd_i.read_table),
    .raddr_i (vpn),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q        <= func_i;
      vaddr_q       <= vaddr_i;
      entry_index_q <= entry_index_i;
      entry_ppn_q   <= entry_ppn_i;
      entry_valid_q <= entry_valid_i;
    end
    if (cmd_i.finish_miss && page_present) begin
      tlb_tag_q[set_idx]   <= tag;
      tlb_frame_q[set_idx] <= ram_rdata;
    end
    if (cmd_i.write_entry) begin
      status_q <= ST_WRITTEN;
      paddr_q  <= '0;
    end else if (cmd_i.finish_hit) begin
      status_q <= ST_TLB;
      paddr_q  <= PADDR_W'({tlb_frame_q[set_idx], offset});
    end else if (cmd_i.finish_miss) begin
      if (page_present) begin
        status_q <= ST_TABLE;
        paddr_q  <= PADDR_W'({ram_rdata, offset});
      end else begin
        status_q <= ST_FAULT;
        paddr_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_present_q   <= '0;
      table_present_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cmd_i.finish_miss && page_present) begin
        tlb_present_q[set_idx] <= 1'b1;
      end
      if (cmd_i.write_entry) begin
        table_present_q[wr_idx] <= entry_valid_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign paddr_o     = paddr_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result register loaded while a result is still pending");

  a_refill_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish_miss && page_present) |=> tlb_present_q[$past(set_idx)])
    else $error("TLB set not marked present after refill");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish_miss && !page_present) |=> (status_q == ST_FAULT && paddr_q == '0))
    else $error("page fault result not posted with a zero address");

endmodule

// File: hdl/tlb_page_table_translator.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  func_i, vaddr_i, entry_index_i,
//                                             entry_ppn_i, entry_valid_i
// result    out        out_valid_o/out_stall_i status_o, paddr_o
//
// A TLB hit and a page-table write load the result register from the execute state
// after acceptance; a TLB miss first does the registered read of the page-table frame
// RAM and loads it from the read state. One transaction is in work at a time, so a new
// one is accepted only once the result of the last has been loaded into the result register.
// While a result waits under out_stall_i, one more transaction is accepted; it then
// holds in its last step with in_stall_o high until the result register frees.
// Reset clears all TLB and page-table present bits at once; no clearing pass is needed.
// Top level of the translator. Depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_dp.
module tlb_page_table_translator import tlbpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   func_i,
  input  logic [VADDR_W-1:0]     vaddr_i,
  input  logic [ENTRY_IDX_W-1:0] entry_index_i,
  input  logic [ENTRY_PPN_W-1:0] entry_ppn_i,
  input  logic                   entry_valid_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [PADDR_W-1:0]     paddr_o
);

  tlbpt_cmd_t   cmd;
  tlbpt_flags_t flags;

  tlbpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  tlbpt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .flags_o       (flags),
    .func_i        (func_i),
    .vaddr_i       (vaddr_i),
    .entry_index_i (entry_index_i),
    .entry_ppn_i   (entry_ppn_i),
    .entry_valid_i (entry_valid_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .paddr_o       (paddr_o)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for tlb_page_table_translator: a directed table, then random
// page-table writes and translations under varying backpressure. Depends on tlbpt_pkg.
module tb;
  import tlbpt_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 10;
  localparam int PHASE_ITEMS  = 510;
  localparam int N_DIRECTED   = 23;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PADDR_W-1:0]  paddr;
  } xlat_result_t;

  typedef struct packed {
    logic                   fn;
    logic [VADDR_W-1:0]     va;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [ENTRY_PPN_W-1:0] ppn;
    logic                   vld;
    logic                   typed;
    logic [STATUS_W-1:0]    st;
    logic [PADDR_W-1:0]     pa;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   func_i = FUNC_TRANSLATE;
  logic [VADDR_W-1:0]     vaddr_i = '0;
  logic [ENTRY_IDX_W-1:0] entry_index_i = '0;
  logic [ENTRY_PPN_W-1:0] entry_ppn_i = '0;
  logic                   entry_valid_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [STATUS_W-1:0]    status_o;
  logic [PADDR_W-1:0]     paddr_o;

  // Typed expectation that travels with the current directed transaction.
  logic                   row_typed = 1'b0;
  logic [STATUS_W-1:0]    row_status = ST_TLB;
  logic [PADDR_W-1:0]     row_paddr = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;
  int n_accepted = 0;
  int n_hit = 0, n_table = 0, n_fault = 0, n_written = 0;

  // Mirror of the page table and the TLB.
  logic [FRAME_BITS-1:0] pt_frame   [TABLE_ENTRIES];
  logic                  pt_present [TABLE_ENTRIES];
  logic [TAG_W-1:0]      tlb_tag    [TLB_SETS];
  logic [FRAME_BITS-1:0] tlb_frame  [TLB_SETS];
  logic                  tlb_present[TLB_SETS];

  xlat_result_t awaited_results[$];

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{FUNC_TRANSLATE, 17'h00000, 7'h00, 15'h0000, 1'b0, 1'b1, ST_FAULT,   25'h0000000},
    '{FUNC_TRANSLATE, 17'h1FFFF, 7'h7F, 15'h7FFF, 1'b1, 1'b1, ST_FAULT,   25'h0000000},
    '{FUNC_WRITE,     17'h1FFFF, 7'h00, 15'h7FFF, 1'b1, 1'b1, ST_WRITTEN, 25'h0000000},
    '{FUNC_WRITE,     17'h00000, 7'h7F, 15'h0000, 1'b1, 1'b1, ST_WRITTEN, 25'h0000000},
    '{FUNC_TRANSLATE, 17'h00000, 7'h00, 15'h0000, 1'b0, 1'b1, ST_TABLE,   25'h1FFFC00},
    '{FUNC_TRANSLATE, 17'h003FF, 7'h00, 15'h0000, 1'b0, 1'b1, ST_TLB,     25'h1FFFFFF},
    '{FUNC_TRANSLATE, 17'h1FFFF, 7'h00, 15'h0000, 1'b0, 1'b1, ST_TABLE,   25'h00003FF},
    '{FUNC_TRANSLATE, 17'h1FC00, 7'h00, 15'h0000, 1'b0, 1'b1, ST_TLB,     25'h0000000},
    '{FUNC_WRITE,     17'h00000, 7'h00, 15'h1234, 1'b0, 1'b1, ST_WRITTEN, 25'h0000000},
    '{FUNC_TRANSLATE, 17'h00155, 7'h00, 15'h0000, 1'b0, 1'b0, ST_TLB,     25'h0000000},
    '{FUNC_WRITE,     17'h00000, 7'h08, 15'h2AAA, 1'b1, 1'b1, ST_WRITTEN, 25'h0000000},
    '{FUNC_TRANSLATE, 17'h022AA, 7'h00, 15'h0000, 1'b0, 1'b0, ST_TLB,     25'h0000000},
    '{FUNC_TRANSLATE, 17'h00001, 7'h00, 15'h0000, 1'b0, 1'b0, ST_TLB,     25'h0000000},
    '{FUNC_WRITE,     17'h00000, 7'h05, 15'h5555, 1'b0, 1'b1, ST_WRITTEN, 25'h0000000},
    '{FUNC_TRANSLATE, 17'h01555, 7'h00, 15'h0000, 1'b0, 1'b0, ST_TLB,     25'h0000000},
    '{FUNC_WRITE,     17'h00000, 7'h05, 15'h5555, 1'b1, 1'b1, ST_WRITTEN, 25'h0000000},
    '{FUNC_TRANSLATE, 17'h01555, 7'h00, 15'h0000, 1'b0, 1'b0, ST_TLB,     25'h0000000},
    '{FUNC_TRANSLATE, 17'h017FF, 7'h00, 15'h0000, 1'b0, 1'b0, ST_TLB,     25'h0000000},
    '{FUNC_WRITE,     17'h1FFFF, 7'h40, 15'h4321, 1'b1, 1'b1, ST_WRITTEN, 25'h0000000},
    '{FUNC_TRANSLATE, 17'h102AA, 7'h7F, 15'h7FFF, 1'b1, 1'b0, ST_TLB,     25'h0000000},
    '{FUNC_TRANSLATE, 17'h1FFFF, 7'h00, 15'h0000, 1'b0, 1'b0, ST_TLB,     25'h0000000},
    '{FUNC_WRITE,     17'h00000, 7'h7F, 15'h0000, 1'b0, 1'b1, ST_WRITTEN, 25'h0000000},
    '{FUNC_TRANSLATE, 17'h1FFFF, 7'h00, 15'h0000, 1'b0, 1'b0, ST_TLB,     25'h0000000}
  };

  tlb_page_table_translator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .vaddr_i      (vaddr_i),
    .entry_index_i(entry_index_i),
    .entry_ppn_i  (entry_ppn_i),
    .entry_valid_i(entry_valid_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .paddr_o      (paddr_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      pt_frame[i]   = '0;
      pt_present[i] = 1'b0;
    end
    for (int i = 0; i < TLB_SETS; i++) begin
      tlb_tag[i]     = '0;
      tlb_frame[i]   = '0;
      tlb_present[i] = 1'b0;
    end
  end

  // Applies one transaction to the mirror and returns the result it must produce.
  function automatic xlat_result_t walk_translation(
    input logic                   fn,
    input logic [VADDR_W-1:0]     va,
    input logic [ENTRY_IDX_W-1:0] idx,
    input logic [ENTRY_PPN_W-1:0] ppn,
    input logic                   vld
  );
    xlat_result_t           r;
    logic [TABLE_IDX_W-1:0] vpn;
    logic [SET_W-1:0]       way_sel;
    logic [TAG_W-1:0]       vtag;
    logic [OFFSET_BITS-1:0] off;
    off     = va[OFFSET_BITS-1:0];
    vpn     = va[OFFSET_BITS +: TABLE_IDX_W];
    way_sel = vpn[SET_W-1:0];
    vtag    = vpn[TABLE_IDX_W-1:SET_W];
    r.paddr = '0;
    if (fn == FUNC_WRITE) begin
      pt_frame[idx]   = ppn[FRAME_BITS-1:0];
      pt_present[idx] = vld;
      r.status        = ST_WRITTEN;
    end else if (tlb_present[way_sel] && tlb_tag[way_sel] == vtag) begin
      r.status = ST_TLB;
      r.paddr  = {tlb_frame[way_sel], off};
    end else if (pt_present[vpn]) begin
      tlb_tag[way_sel]     = vtag;
      tlb_frame[way_sel]   = pt_frame[vpn];
      tlb_present[way_sel] = 1'b1;
      r.status             = ST_TABLE;
      r.paddr              = {pt_frame[vpn], off};
    end else begin
      r.status = ST_FAULT;
    end
    return r;
  endfunction

  // Predicts on every accepted input transaction and checks every accepted result.
  always @(posedge clk_i) begin : scoreboard
    xlat_result_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      want = walk_translation(func_i, vaddr_i, entry_index_i, entry_ppn_i, entry_valid_i);
      if (row_typed) begin
        want.status = row_status;
        want.paddr  = row_paddr;
      end
      case (want.status)
        ST_TLB:   n_hit++;
        ST_TABLE: n_table++;
        ST_FAULT: n_fault++;
        default:  n_written++;
      endcase
      n_accepted++;
      awaited_results.push_back(want);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing expected: status %0d paddr 0x%07h",
               status_o, paddr_o);
        mismatch_cnt++;
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status_o);
          mismatch_cnt++;
        end
        if (paddr_o !== want.paddr) begin
          $error("paddr mismatch: expected 0x%07h, got 0x%07h", want.paddr, paddr_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the caller either offers again or lowers it.
  task automatic offer_txn(
    input logic                   fn,
    input logic [VADDR_W-1:0]     va,
    input logic [ENTRY_IDX_W-1:0] idx,
    input logic [ENTRY_PPN_W-1:0] ppn,
    input logic                   vld,
    input logic                   typed,
    input logic [STATUS_W-1:0]    st,
    input logic [PADDR_W-1:0]     pa
  );
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    vaddr_i       <= va;
    entry_index_i <= idx;
    entry_ppn_i   <= ppn;
    entry_valid_i <= vld;
    row_typed     <= typed;
    row_status    <= st;
    row_paddr     <= pa;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Mostly writes and lookups around a sliding window of hot pages, so that
  // sets conflict, refills replace each other and stale entries get hit.
  task automatic offer_random(input int hot_base);
    int                     pick;
    logic [TABLE_IDX_W-1:0] pg;
    logic [OFFSET_BITS-1:0] off;
    logic [VADDR_W-1:0]     va;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [ENTRY_PPN_W-1:0] ppn;
    pick = $urandom_range(0, 99);
    pg   = TABLE_IDX_W'((hot_base + $urandom_range(0, 23)) % TABLE_ENTRIES);
    off  = OFFSET_BITS'($urandom);
    va   = VADDR_W'($urandom);
    idx  = ENTRY_IDX_W'($urandom);
    ppn  = ENTRY_PPN_W'($urandom);
    if (pick < 15) begin
      offer_txn(1'($urandom_range(0, 1)), va, idx, ppn, 1'($urandom_range(0, 1)),
                1'b0, ST_TLB, '0);
    end else if (pick < 40) begin
      offer_txn(FUNC_WRITE, va, pg, ppn, ($urandom_range(0, 99) < 85), 1'b0, ST_TLB, '0);
    end else begin
      offer_txn(FUNC_TRANSLATE, {pg, off}, idx, ppn, 1'($urandom_range(0, 1)),
                1'b0, ST_TLB, '0);
    end
  endtask

  initial begin : stimulus
    int hot_base;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 13;
    rx_idle_pct = 50;
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_txn(directed_rows[i].fn, directed_rows[i].va, directed_rows[i].idx,
                directed_rows[i].ppn, directed_rows[i].vld, directed_rows[i].typed,
                directed_rows[i].st, directed_rows[i].pa);
    end
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 13; rx_idle_pct = 50; end
        1: begin tx_idle_pct = 50; rx_idle_pct = 13; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      hot_base = $urandom_range(0, TABLE_ENTRIES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 128 == 127) hot_base = $urandom_range(0, TABLE_ENTRIES - 1);
        // Long result-side hold-off while transactions keep coming.
        if (phase == 0 && n == 60) hold_req = 1'b1;
        offer_random(hot_base);
      end
      drain_results();
    end

    $display("%0d transactions checked: %0d TLB hits, %0d page-table reads,", n_accepted,
             n_hit, n_table);
    $display("%0d page faults and %0d entry writes, over three backpressure mixes", n_fault,
             n_written);
    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
